/* rtl/vpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_pkg
// shared constants and types of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned MaxParts  = 32;
  localparam int unsigned AddrBits  = 20;
  localparam int unsigned OwnerBits = 16;
  localparam int unsigned IdxBits   = $clog2(MaxParts);
  localparam int unsigned CntBits   = $clog2(MaxParts + 1);
  localparam int unsigned SizeBits  = AddrBits + 1;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StNoMatch = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic OpAlloc = 1'b0;

  localparam logic RegFit  = 1'b0;
  localparam logic RegSize = 1'b1;

  typedef struct packed {
    logic [AddrBits-1:0]  start;
    logic [AddrBits-1:0]  last_addr;
    logic                 is_free;
    logic [OwnerBits-1:0] owner;
  } part_t;

endpackage
`default_nettype wire

/* rtl/variable_partition_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_partition_allocator
// address-ordered partition table with first, best or worst fit placement
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel (allocate or free), and each one is
// answered on m_axis by a listing of every partition in address order, with
// tlast on the final partition. The APB port sets the fit policy and the
// memory size; writing the size reinitializes the table to one free block.
// A request scans the table (up to 32 partitions) and decides, then shifts
// entries on a split or a merge, then lists every partition in turn; one
// table entry is read or moved per cycle by a single sequencer with one size
// subtract and compare unit, though the listing waits while m_axis_tready
// is low. s_axis_tready is low from acceptance until the last partition of
// the listing has been transferred. After reset the table holds one free
// block of 1048576 units, fit policy first-fit. A stall on m_axis_tready
// holds the current result item and the sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
module variable_partition_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sequence_number, [16] operation, [32:17] owner_id,
  // [53:33] request_size, [55:54] zero
  input  wire  [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [15:0] sequence_echo, [17:16] status, [37:18] block_start,
  // [57:38] block_end, [58] block_free, [74:59] block_owner, [79:75] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vpa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_SHUP  = 7'b0001000,
    S_SHDN  = 7'b0010000,
    S_MERGE = 7'b0100000,
    S_LIST  = 7'b1000000
  } state_e;

  state_e state_q;
  part_t tbl_q [MaxParts];
  logic [CntBits-1:0] cnt_q;
  logic [1:0] fit_q;
  logic [SizeBits-1:0] msize_q;
  logic [15:0] seq_q;
  logic op_q;
  logic [OwnerBits-1:0] pid_q;
  logic [SizeBits-1:0] rsize_q, best_q;
  logic [CntBits-1:0] i_q, pick_q;
  logic found_q;
  logic [1:0] status_q;
  logic [CntBits-1:0] rm_q;
  logic merge_prev_q;
  logic out_v_q;

  part_t cur;
  logic [SizeBits-1:0] csize;
  logic wr_en, size_wr;
  logic [SizeBits-1:0] wsize;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign size_wr = wr_en && paddr[2] == RegSize;

  always_comb begin
    if (paddr[2] == RegFit) prdata = {30'd0, fit_q};
    else prdata = {{(32-SizeBits){1'b0}}, msize_q};
  end

  always_comb begin
    wsize = pwdata[SizeBits-1:0];
    if (wsize == '0) wsize = SizeBits'(1);
    if (wsize > (SizeBits'(1) << AddrBits)) wsize = SizeBits'(1) << AddrBits;
  end

  assign cur = tbl_q[i_q[IdxBits-1:0]];
  assign csize = SizeBits'(cur.last_addr) - SizeBits'(cur.start) + SizeBits'(1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast = (i_q == cnt_q - CntBits'(1));
  assign m_axis_tdata = {5'd0, cur.is_free ? {OwnerBits{1'b0}} : cur.owner, cur.is_free,
                         cur.last_addr, cur.start, status_q, seq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= CntBits'(1);
      fit_q <= FitFirst;
      msize_q <= SizeBits'(1) << AddrBits;
      out_v_q <= 1'b0;
      i_q <= '0;
      tbl_q[0] <= '{start: '0, last_addr: '1, is_free: 1'b1, owner: '0};
    end else begin
      if (wr_en && paddr[2] == RegFit) fit_q <= pwdata[1:0];
      if (size_wr) begin
        msize_q <= wsize;
        cnt_q <= CntBits'(1);
        tbl_q[0] <= '{start: '0, last_addr: AddrBits'(wsize - SizeBits'(1)),
                      is_free: 1'b1, owner: '0};
      end
      unique case (state_q)
        S_IDLE: begin
          i_q <= '0;
          found_q <= 1'b0;
          if (s_axis_tvalid) begin
            state_q <= S_SCAN;
            seq_q <= s_axis_tdata[15:0];
            op_q <= s_axis_tdata[16];
            pid_q <= s_axis_tdata[17 +: OwnerBits];
            rsize_q <= s_axis_tdata[53:33];
          end
        end
        S_SCAN: begin
          if (i_q == cnt_q) begin
            state_q <= S_DEC;
          end else begin
            i_q <= i_q + CntBits'(1);
            if (op_q == OpAlloc) begin
              if (cur.is_free && csize >= rsize_q && rsize_q != '0) begin
                priority if (!found_q) begin
                  found_q <= 1'b1; pick_q <= i_q; best_q <= csize;
                end else if (fit_q == FitBest && csize < best_q) begin
                  pick_q <= i_q; best_q <= csize;
                end else if (fit_q[1] && csize > best_q) begin
                  pick_q <= i_q; best_q <= csize;
                end
              end
            end else if (!found_q && !cur.is_free && cur.owner == pid_q &&
                         csize == rsize_q) begin
              found_q <= 1'b1; pick_q <= i_q;
            end
          end
        end
        S_DEC: begin
          // decide outcome, then start any shifts, one entry per cycle
          if (op_q == OpAlloc) begin
            if (!found_q) begin
              status_q <= StNoFit; i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
            end else if (best_q != rsize_q && cnt_q == CntBits'(MaxParts)) begin
              status_q <= StFull; i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
            end else if (best_q != rsize_q) begin
              status_q <= StDone;
              i_q <= cnt_q;
              state_q <= S_SHUP;
            end else begin
              status_q <= StDone;
              tbl_q[pick_q[IdxBits-1:0]].is_free <= 1'b0;
              tbl_q[pick_q[IdxBits-1:0]].owner <= pid_q;
              i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
            end
          end else if (!found_q) begin
            status_q <= StNoMatch; i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
          end else begin
            status_q <= StDone;
            tbl_q[pick_q[IdxBits-1:0]].is_free <= 1'b1;
            tbl_q[pick_q[IdxBits-1:0]].owner <= '0;
            state_q <= S_MERGE;
            merge_prev_q <= 1'b0;
            rm_q <= '0;
          end
        end
        S_SHUP: begin
          if (i_q > pick_q + CntBits'(1)) begin
            tbl_q[i_q[IdxBits-1:0]] <= tbl_q[i_q[IdxBits-1:0] - IdxBits'(1)];
            i_q <= i_q - CntBits'(1);
          end else begin
            tbl_q[i_q[IdxBits-1:0]].start <= tbl_q[pick_q[IdxBits-1:0]].start
                                             + rsize_q[AddrBits-1:0];
            tbl_q[i_q[IdxBits-1:0]].last_addr <= tbl_q[pick_q[IdxBits-1:0]].last_addr;
            tbl_q[i_q[IdxBits-1:0]].is_free <= 1'b1;
            tbl_q[i_q[IdxBits-1:0]].owner <= '0;
            tbl_q[pick_q[IdxBits-1:0]].last_addr <= tbl_q[pick_q[IdxBits-1:0]].start
                                                    + rsize_q[AddrBits-1:0] - AddrBits'(1);
            tbl_q[pick_q[IdxBits-1:0]].is_free <= 1'b0;
            tbl_q[pick_q[IdxBits-1:0]].owner <= pid_q;
            cnt_q <= cnt_q + CntBits'(1);
            i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
          end
        end
        S_MERGE: begin
          // merge with next, then with previous, each a down shift
          if (!merge_prev_q) begin
            merge_prev_q <= 1'b1;
            if (pick_q + CntBits'(1) < cnt_q &&
                tbl_q[pick_q[IdxBits-1:0] + IdxBits'(1)].is_free) begin
              tbl_q[pick_q[IdxBits-1:0]].last_addr <=
                tbl_q[pick_q[IdxBits-1:0] + IdxBits'(1)].last_addr;
              i_q <= pick_q + CntBits'(1);
              rm_q <= pick_q + CntBits'(1);
              state_q <= S_SHDN;
            end
          end else begin
            if (pick_q != '0 && tbl_q[pick_q[IdxBits-1:0] - IdxBits'(1)].is_free) begin
              tbl_q[pick_q[IdxBits-1:0] - IdxBits'(1)].last_addr <=
                tbl_q[pick_q[IdxBits-1:0]].last_addr;
              i_q <= pick_q;
              rm_q <= '0;
              pick_q <= '0;
              state_q <= S_SHDN;
            end else begin
              i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
            end
          end
        end
        S_SHDN: begin
          if (i_q + CntBits'(1) < cnt_q) begin
            tbl_q[i_q[IdxBits-1:0]] <= tbl_q[i_q[IdxBits-1:0] + IdxBits'(1)];
            i_q <= i_q + CntBits'(1);
          end else begin
            cnt_q <= cnt_q - CntBits'(1);
            if (rm_q != '0) state_q <= S_MERGE;
            else begin
              i_q <= '0; state_q <= S_LIST; out_v_q <= 1'b1;
            end
          end
        end
        S_LIST: begin
          if (m_axis_tready) begin
            if (m_axis_tlast) begin
              out_v_q <= 1'b0; state_q <= S_IDLE; i_q <= '0;
            end else i_q <= i_q + CntBits'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* dv/variable_partition_allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_checker
// watches the request, listing and register channels, keeps its own copy of
// the partition table and compares every listed partition field by field
// ----------------------------------------------------------------------------
module variable_partition_allocator_checker
  import vpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_o,
  output int          errors_o
);

  typedef struct {
    logic [15:0]          seq;
    logic [1:0]           status;
    logic [AddrBits-1:0]  first;
    logic [AddrBits-1:0]  final_addr;
    logic                 is_free;
    logic [OwnerBits-1:0] owner;
    logic                 tail;
  } listing_t;

  logic [SizeBits-1:0]  tbl_start [MaxParts];
  logic [SizeBits-1:0]  tbl_end   [MaxParts];
  logic                 tbl_free  [MaxParts];
  logic [OwnerBits-1:0] tbl_owner [MaxParts];
  int                   tbl_cnt;
  logic [1:0]           policy;
  logic [SizeBits-1:0]  mem_units;
  listing_t             listing_q[$];

  function automatic logic [SizeBits-1:0] span(int i);
    return tbl_end[i] - tbl_start[i] + SizeBits'(1);
  endfunction

  function automatic void clear_table();
    tbl_cnt = 1;
    tbl_start[0] = '0;
    tbl_end[0] = mem_units - SizeBits'(1);
    tbl_free[0] = 1'b1;
    tbl_owner[0] = '0;
  endfunction

  function automatic void drop(int i);
    for (int k = i; k + 1 < tbl_cnt; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_end[k] = tbl_end[k+1];
      tbl_free[k] = tbl_free[k+1];
      tbl_owner[k] = tbl_owner[k+1];
    end
    tbl_cnt--;
  endfunction

  function automatic logic [1:0] place(logic [SizeBits-1:0] want, logic [OwnerBits-1:0] pid);
    int pick;
    logic [SizeBits-1:0] best;
    logic [SizeBits-1:0] s;
    pick = -1;
    best = '0;
    if (want == 0) return StNoFit;
    for (int i = 0; i < tbl_cnt; i++) begin
      if (!tbl_free[i]) continue;
      s = span(i);
      if (s < want) continue;
      if (policy == FitFirst) begin
        pick = i;
        break;
      end else if (policy == FitBest) begin
        if (pick < 0 || s < best) begin
          pick = i;
          best = s;
        end
      end else if (pick < 0 || s > best) begin
        pick = i;
        best = s;
      end
    end
    if (pick < 0) return StNoFit;
    if (span(pick) > want) begin
      if (tbl_cnt >= MaxParts) return StFull;
      for (int k = tbl_cnt; k > pick + 1; k--) begin
        tbl_start[k] = tbl_start[k-1];
        tbl_end[k] = tbl_end[k-1];
        tbl_free[k] = tbl_free[k-1];
        tbl_owner[k] = tbl_owner[k-1];
      end
      tbl_cnt++;
      tbl_start[pick+1] = tbl_start[pick] + want;
      tbl_end[pick+1] = tbl_end[pick];
      tbl_free[pick+1] = 1'b1;
      tbl_owner[pick+1] = '0;
      tbl_end[pick] = tbl_start[pick] + want - SizeBits'(1);
    end
    tbl_free[pick] = 1'b0;
    tbl_owner[pick] = pid;
    return StDone;
  endfunction

  function automatic logic [1:0] release_block(logic [SizeBits-1:0] want,
                                               logic [OwnerBits-1:0] pid);
    int i;
    for (i = 0; i < tbl_cnt; i++)
      if (!tbl_free[i] && tbl_owner[i] == pid && span(i) == want) break;
    if (i == tbl_cnt) return StNoMatch;
    tbl_free[i] = 1'b1;
    tbl_owner[i] = '0;
    if (i + 1 < tbl_cnt && tbl_free[i+1]) begin
      tbl_end[i] = tbl_end[i+1];
      drop(i + 1);
    end
    if (i > 0 && tbl_free[i-1]) begin
      tbl_end[i-1] = tbl_end[i];
      drop(i);
    end
    return StDone;
  endfunction

  function automatic void predict(logic [55:0] req);
    logic [1:0] st;
    listing_t item;
    if (req[16] == OpAlloc) st = place(req[53:33], req[32:17]);
    else st = release_block(req[53:33], req[32:17]);
    for (int i = 0; i < tbl_cnt; i++) begin
      item.seq = req[15:0];
      item.status = st;
      item.first = tbl_start[i][AddrBits-1:0];
      item.final_addr = tbl_end[i][AddrBits-1:0];
      item.is_free = tbl_free[i];
      item.owner = tbl_free[i] ? '0 : tbl_owner[i];
      item.tail = (i + 1 == tbl_cnt);
      listing_q.push_back(item);
    end
  endfunction

  function automatic void write_reg(logic [2:0] addr, logic [31:0] data);
    logic [SizeBits-1:0] v;
    if (addr[2] == RegSize) begin
      v = data[20:0];
      if (data[20:0] == 0) v = SizeBits'(1);
      if (data[20:0] > (1 << AddrBits)) v = SizeBits'(1) << AddrBits;
      mem_units = v;
      clear_table();
    end else begin
      policy = data[1:0];
    end
  endfunction

  function automatic void compare(listing_t want, logic [79:0] got, logic got_last);
    if (got[15:0] !== want.seq || got[17:16] !== want.status ||
        got[37:18] !== want.first || got[57:38] !== want.final_addr ||
        got[58] !== want.is_free || got[74:59] !== want.owner ||
        got_last !== want.tail) begin
      errors_o++;
      if (errors_o <= 10)
        $display("mismatch: seq %h/%h st %0d/%0d start %h/%h end %h/%h free %b/%b own %h/%h last %b/%b",
                 want.seq, got[15:0], want.status, got[17:16], want.first, got[37:18],
                 want.final_addr, got[57:38], want.is_free, got[58], want.owner,
                 got[74:59], want.tail, got_last);
    end
  endfunction

  initial begin
    errors_o = 0;
    pending_o = 0;
    policy = FitFirst;
    mem_units = SizeBits'(1) << AddrBits;
    clear_table();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) write_reg(paddr, pwdata);
      if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (listing_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected transfer: %h", m_axis_tdata);
        end else begin
          compare(listing_q.pop_front(), m_axis_tdata, m_axis_tlast);
        end
      end
    end
    pending_o <= listing_q.size();
  end

endmodule

/* dv/variable_partition_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_tb
// drives directed and random allocate and free requests under several fit
// policies and memory sizes, with random gaps and stalls and one long hold
// ----------------------------------------------------------------------------
module variable_partition_allocator_tb;
  import vpa_pkg::*;

  localparam int Limit = 2000000;

  typedef struct {
    logic [15:0] pid;
    logic [20:0] size;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          hold_left = 0;
  logic [15:0] seq = '0;
  int          mem_now = 1 << AddrBits;
  grant_t      grants[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  variable_partition_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  variable_partition_allocator_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("variable_partition_allocator_tb: done, errors");
      $finish;
    end
  end

  // receiver, with one long hold while requests keep coming
  always @(posedge clk) begin
    if (cycles == 6000) begin
      hold_left <= 600;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  task automatic send(logic op, logic [15:0] pid, logic [20:0] size);
    if (!calm && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tdata <= {2'b00, size, pid, op, seq};
    s_tvalid <= 1'b1;
    seq = 16'($urandom);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic alloc(logic [15:0] pid, logic [20:0] size);
    grant_t g;
    g.pid = pid;
    g.size = size;
    grants.push_back(g);
    send(OpAlloc, pid, size);
  endtask

  task automatic release_grant();
    int k;
    grant_t g;
    k = $urandom_range(0, grants.size() - 1);
    g = grants[k];
    grants.delete(k);
    send(!OpAlloc, g.pid, g.size);
  endtask

  task automatic random_phase(logic [1:0] pol, logic [31:0] msize, int count);
    int r;
    logic [20:0] sz;
    settle();
    write_reg(RegFit, {30'd0, pol});
    write_reg(RegSize, msize);
    grants.delete();
    mem_now = int'(msize[20:0]);
    if (mem_now == 0) mem_now = 1;
    else if (mem_now > (1 << AddrBits)) mem_now = 1 << AddrBits;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send(r[0], 16'($urandom), 21'($urandom_range(0, 1 << AddrBits)));
      end else if (r < 45 && grants.size() > 0) begin
        release_grant();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) sz = '0;
        else if (r < 9) sz = 21'($urandom_range(mem_now / 2, mem_now));
        else sz = 21'($urandom_range(1, mem_now / 8 + 1));
        alloc(16'($urandom), sz);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: exact fit of whole memory, no fit, no match, merges
    alloc(16'h0001, 21'd0);
    alloc(16'hFFFF, 21'h100000);
    alloc(16'h0002, 21'd1);
    send(!OpAlloc, 16'hFFFF, 21'd5);
    send(!OpAlloc, 16'hFFFF, 21'h100000);
    alloc(16'h0001, 21'd100);
    alloc(16'h0002, 21'd200);
    alloc(16'h0003, 21'd300);
    alloc(16'h0004, 21'hFFFFF);
    send(!OpAlloc, 16'h0002, 21'd200);
    send(!OpAlloc, 16'h0001, 21'd100);
    alloc(16'h0005, 21'd50);
    send(!OpAlloc, 16'h0003, 21'd300);
    send(!OpAlloc, 16'h0004, 21'hFFFFF);
    send(!OpAlloc, 16'h0005, 21'd50);
    random_phase(FitBest, 32'd200, 50);
    random_phase(2'd2, 32'd48, 60);
    random_phase(2'd3, 32'hFFFFFFFF, 50);
    calm = 1'b1;
    random_phase(FitFirst, 32'd48, 50);
    calm = 1'b0;
    random_phase(FitBest, 32'd0, 10);
    random_phase(2'd2, 32'h100000, 50);
    random_phase(FitFirst, 32'd1, 10);
    random_phase(FitBest, 32'd40, 65);
    settle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("variable_partition_allocator_tb: done, clean");
    end else begin
      $display("variable_partition_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule
